@@ sv/fisq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fisq_pkg
// Constants and binary32 arithmetic helpers for the fast inverse square root.
// ----------------------------------------------------------------------------
package fisq_pkg;

	localparam logic [31:0] MAGIC_GUESS      = 32'h5f3759df;
	localparam logic [31:0] HALF_BITS        = 32'h3F000000;
	localparam logic [31:0] THREEHALVES_BITS = 32'h3FC00000;
	localparam logic [31:0] QUIET_BIT        = 32'h00400000;
	localparam logic [31:0] DEFAULT_NAN      = 32'h7FC00000;
	localparam logic [30:0] EXP_ALL_ONES     = 31'h7F800000;
	localparam int          LATENCY          = 5;

	function automatic logic is_nan(input logic [31:0] a);
		return a[30:0] > EXP_ALL_ONES;
	endfunction

	function automatic logic is_inf(input logic [31:0] a);
		return a[30:0] == EXP_ALL_ONES;
	endfunction

	function automatic logic is_zero(input logic [31:0] a);
		return a[30:0] == 31'd0;
	endfunction

	function automatic logic [5:0] clz48(input logic [47:0] p);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (p[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	function automatic logic [5:0] clz51(input logic [50:0] p);
		logic [5:0] n;
		n = 6'd51;
		for (int i = 0; i < 51; i++) begin
			if (p[i]) n = 6'(50 - i);
		end
		return n;
	endfunction

	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		logic              s;
		logic [7:0]        ea;
		logic [7:0]        eb;
		logic [47:0]       p;
		logic [47:0]       pn;
		logic [5:0]        lz;
		logic signed [10:0] ex;
		logic [6:0]        sh;
		logic [7:0]        field;
		logic [97:0]       pw;
		logic [23:0]       m;
		logic              g;
		logic              st;
		logic [30:0]       mag;
		s = a[31] ^ b[31];
		if (is_nan(a)) return a | QUIET_BIT;
		if (is_nan(b)) return b | QUIET_BIT;
		if (is_inf(a) || is_inf(b)) begin
			if (is_zero(a) || is_zero(b)) return DEFAULT_NAN;
			return {s, EXP_ALL_ONES};
		end
		if (is_zero(a) || is_zero(b)) return {s, 31'd0};
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		p  = {(a[30:23] != 8'd0), a[22:0]} * {(b[30:23] != 8'd0), b[22:0]};
		lz = clz48(p);
		pn = p << lz;
		ex = $signed(11'(ea)) + $signed(11'(eb)) - 11'sd126 - $signed(11'(lz));
		if (ex >= 11'sd255) return {s, EXP_ALL_ONES};
		if (ex <= 11'sd0) begin
			sh    = (ex < -11'sd48) ? 7'd50 : 7'(11'sd1 - ex);
			field = 8'd0;
		end else begin
			sh    = 7'd0;
			field = ex[7:0];
		end
		pw  = {pn, 50'd0} >> sh;
		m   = pw[97:74];
		g   = pw[73];
		st  = |pw[72:0];
		mag = {field, m[22:0]} + 31'(g & (st | m[0]));
		return {s, mag};
	endfunction

	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		logic [31:0]        x;
		logic [31:0]        y;
		logic               sub;
		logic [7:0]         exe;
		logic [7:0]         eye;
		logic [7:0]         d;
		logic [49:0]        b50;
		logic [49:0]        bsh;
		logic               stk;
		logic [50:0]        av;
		logic [50:0]        bv;
		logic [50:0]        sm;
		logic [50:0]        sn;
		logic [5:0]         lz;
		logic signed [10:0] exn;
		logic [7:0]         field;
		logic [23:0]        m;
		logic               g;
		logic               st;
		logic [30:0]        mag;
		if (a[30:0] < b[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		sub = x[31] ^ y[31];
		exe = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		eye = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		d   = exe - eye;
		b50 = {(y[30:23] != 8'd0), y[22:0], 26'd0};
		if (d >= 8'd50) begin
			bsh = 50'd0;
			stk = |b50;
		end else begin
			bsh = b50 >> d;
			stk = (bsh << d) != b50;
		end
		av = {1'b0, (x[30:23] != 8'd0), x[22:0], 26'd0};
		bv = {1'b0, bsh[49:1], bsh[0] | stk};
		sm = sub ? (av - bv) : (av + bv);
		if (sm == 51'd0) return sub ? 32'd0 : {x[31], 31'd0};
		lz  = clz51(sm);
		exn = $signed(11'(exe)) + 11'sd1 - $signed(11'(lz));
		if (exn >= 11'sd255) return {x[31], EXP_ALL_ONES};
		if (exn <= 11'sd0) begin
			sn    = sm << exe;
			field = 8'd0;
		end else begin
			sn    = sm << lz;
			field = exn[7:0];
		end
		m   = sn[50:27];
		g   = sn[26];
		st  = |sn[25:0];
		mag = {field, m[22:0]} + 31'(g & (st | m[0]));
		return {x[31], mag};
	endfunction

	function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
		if (is_nan(a)) return a | QUIET_BIT;
		if (is_nan(b)) return b | QUIET_BIT;
		if (is_inf(a) && is_inf(b)) begin
			if (a[31] == b[31]) return DEFAULT_NAN;
			return a;
		end
		if (is_inf(a)) return a;
		if (is_inf(b)) return {~b[31], b[30:0]};
		return fp_add(a, {~b[31], b[30:0]});
	endfunction

endpackage
`default_nettype wire

@@ sv/fast_inverse_sqrt_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_top
// Five-stage pipeline computing the fast inverse square root of a binary32.
// ----------------------------------------------------------------------------
// Input channel: in_valid, in_stall, value_bits. A transfer happens on a rising
// edge with in_valid high and in_stall low.
// Output channel: out_valid, out_stall, result_bits, same rule.
// Stages: halving and first guess, then one binary32 multiply or subtract per
// stage (x2*y, *y, 1.5-t, y*t), each with its own normalize and round.
// An input transfer reaches out_valid through stage registers s1 to s5; one item
// is taken every cycle unless a stalled output holds the pipeline.
// While out_valid is high and out_stall is high the whole pipeline holds and
// in_stall is raised, so nothing is lost or repeated; out_stall alone, with
// an empty output register, does not stop the pipeline.
// Reset (arst_n low) clears all valid bits at once; the pipeline is empty and
// ready after reset.
// ----------------------------------------------------------------------------
module fast_inverse_sqrt_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] value_bits,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      result_bits
);
	import fisq_pkg::*;

	logic        adv;
	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [31:0] half_s1, guess_s1;
	logic [31:0] t_s2, guess_s2;
	logic [31:0] t_s3, guess_s3;
	logic [31:0] t_s4, guess_s4;
	logic [31:0] result_s5;

	assign adv      = !(valid_s5 && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			half_s1   <= fp_mul(value_bits, HALF_BITS);
			guess_s1  <= MAGIC_GUESS - {value_bits[31], value_bits[31:1]};
			t_s2      <= fp_mul(half_s1, guess_s1);
			guess_s2  <= guess_s1;
			t_s3      <= fp_mul(t_s2, guess_s2);
			guess_s3  <= guess_s2;
			t_s4      <= fp_sub(THREEHALVES_BITS, t_s3);
			guess_s4  <= guess_s3;
			result_s5 <= fp_mul(guess_s4, t_s4);
		end
	end

	assign out_valid   = valid_s5;
	assign result_bits = result_s5;

endmodule
`default_nettype wire

@@ sv/fisq_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fisq_checker
// Port-level checks for the fast inverse square root pipeline.
// ----------------------------------------------------------------------------
module fisq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] result_bits
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_bits))
		else $error("stalled output transfer changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked output");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
		##1 !out_stall |=> out_valid)
		else $error("accepted item did not reach the output in time");

endmodule

bind fast_inverse_sqrt_top fisq_checker u_fisq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_bits (result_bits)
);
`default_nettype wire

@@ tb/fast_inverse_sqrt_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_top_tb
// Drives binary32 patterns into the fast inverse square root pipeline and
// checks every result against an integer-exact binary32 predictor (halving,
// magic-constant guess, one Newton step, round to nearest-even, subnormals
// kept), under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module fast_inverse_sqrt_top_tb;
	import fisq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] value_bits;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result_bits;

	logic        in_fire = 1'b0;
	int          cycles = 0;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          n_sub;
	int          n_special;

	fast_inverse_sqrt_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .value_bits(value_bits),
		.out_valid(out_valid), .out_stall(out_stall), .result_bits(result_bits)
	);

	function automatic bit fl_nan(input logic [31:0] a);
		return a[30:23] == 8'hff && a[22:0] != 23'd0;
	endfunction

	function automatic bit fl_inf(input logic [31:0] a);
		return a[30:0] == {8'hff, 23'd0};
	endfunction

	// value = sig * 2^e, rounded to binary32
	function automatic logic [31:0] fl_pack(input logic sgn, input int e, input logic [63:0] sig);
		int           p;
		int           ebias;
		int           q;
		int           sh;
		logic [127:0] w;
		logic [63:0]  kept;
		logic [63:0]  mag;
		logic         g;
		logic         st;
		if (sig == 64'd0) return {sgn, 31'd0};
		p = 0;
		for (int i = 0; i < 64; i++) if (sig[i]) p = i;
		ebias = e + p + 127;
		if (ebias >= 255) return {sgn, 8'hff, 23'd0};
		q  = (ebias >= 1) ? e + p - 23 : -149;
		sh = q - e;
		if (sh <= 0) begin
			kept = sig << (-sh);
			g    = 1'b0;
			st   = 1'b0;
		end else if (sh > 64) begin
			kept = 64'd0;
			g    = 1'b0;
			st   = 1'b1;
		end else begin
			w    = {sig, 64'd0} >> sh;
			kept = w[127:64];
			g    = w[63];
			st   = |w[62:0];
		end
		mag = kept + 64'(g & (st | kept[0]));
		if (ebias >= 1) mag = mag + (64'(ebias - 1) << 23);
		return {sgn, mag[30:0]};
	endfunction

	function automatic void fl_unpack(input logic [31:0] a, output logic [63:0] sig,
			output int e);
		if (a[30:23] == 8'd0) begin
			sig = 64'(a[22:0]);
			e   = -149;
		end else begin
			sig = 64'({1'b1, a[22:0]});
			e   = int'(a[30:23]) - 150;
		end
	endfunction

	function automatic logic [31:0] fl_mul(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] sa;
		logic [63:0] sb;
		int          ea;
		int          eb;
		logic        sgn;
		sgn = a[31] ^ b[31];
		if (fl_nan(a)) return a | QUIET_BIT;
		if (fl_nan(b)) return b | QUIET_BIT;
		if (fl_inf(a) || fl_inf(b)) begin
			if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return DEFAULT_NAN;
			return {sgn, 8'hff, 23'd0};
		end
		fl_unpack(a, sa, ea);
		fl_unpack(b, sb, eb);
		return fl_pack(sgn, ea + eb, sa * sb);
	endfunction

	function automatic logic [31:0] fl_sub(input logic [31:0] a, input logic [31:0] b);
		logic [31:0]        nb;
		logic [31:0]        x;
		logic [31:0]        y;
		logic [63:0]        sx;
		logic [63:0]        sy;
		logic [63:0]        ya;
		int                 ex;
		int                 ey;
		int                 d;
		logic signed [65:0] acc;
		if (fl_nan(a)) return a | QUIET_BIT;
		if (fl_nan(b)) return b | QUIET_BIT;
		nb = {~b[31], b[30:0]};
		if (fl_inf(a) && fl_inf(b)) return (a[31] == b[31]) ? DEFAULT_NAN : a;
		if (fl_inf(a)) return a;
		if (fl_inf(b)) return nb;
		if (a[30:23] >= b[30:23]) begin
			x = a;
			y = nb;
		end else begin
			x = nb;
			y = a;
		end
		fl_unpack(x, sx, ex);
		fl_unpack(y, sy, ey);
		d = ex - ey;
		if (d <= 40) ya = sy << (40 - d);
		else if (d - 40 >= 64) ya = 64'(sy != 64'd0);
		else ya = (sy >> (d - 40)) | 64'(((sy >> (d - 40)) << (d - 40)) != sy);
		acc = (x[31] ? -$signed({2'b0, sx << 40}) : $signed({2'b0, sx << 40}))
			+ (y[31] ? -$signed({2'b0, ya}) : $signed({2'b0, ya}));
		if (acc == 66'sd0) return {a[31] & ~b[31], 31'd0};
		if (acc < 0) return fl_pack(1'b1, ex - 40, 64'(-acc));
		return fl_pack(1'b0, ex - 40, 64'(acc));
	endfunction

	function automatic logic [31:0] rsqrt_estimate(input logic [31:0] v);
		logic [31:0] half;
		logic [31:0] guess;
		logic [31:0] t;
		half  = fl_mul(v, HALF_BITS);
		guess = MAGIC_GUESS - {v[31], v[31:1]};
		t     = fl_mul(half, guess);
		t     = fl_mul(t, guess);
		t     = fl_sub(THREEHALVES_BITS, t);
		return fl_mul(guess, t);
	endfunction

	class rsqrt_scoreboard;
		logic [31:0] operands[$];
		logic [31:0] expected[$];
		int          errors;
		int          n_in;
		int          n_out;

		task report(input string what, input logic [31:0] op, input logic [31:0] got,
				input logic [31:0] want);
			$display("mismatch %0s: operand %08h got %08h want %08h", what, op, got, want);
			errors++;
		endtask

		function void note_input(input logic [31:0] v);
			operands = {operands, v};
			expected = {expected, rsqrt_estimate(v)};
			n_in++;
		endfunction

		task check_result(input logic [31:0] r);
			logic [31:0] op;
			logic [31:0] want;
			n_out++;
			if (expected.size() == 0) begin
				report("unexpected result", 32'd0, r, 32'd0);
			end else begin
				op   = operands.pop_front();
				want = expected.pop_front();
				if (r !== want) report("result_bits", op, r, want);
			end
		endtask
	endclass

	rsqrt_scoreboard sb;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("fast_inverse_sqrt_top_tb: FAIL");
			$finish;
		end
	end

	// sample both channels away from the driving edge
	always @(negedge clk) begin
		in_fire <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_input(value_bits);
			if (out_valid && !out_stall) sb.check_result(result_bits);
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	task send(input logic [31:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		if (v[30:23] == 8'd0) n_sub++;
		if (v[30:23] == 8'hff) n_special++;
		in_valid   <= 1'b1;
		value_bits <= v;
		do @(posedge clk); while (!in_fire);
	endtask

	task drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] random_operand();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return {1'b0, 8'($urandom_range(60, 190)), 23'($urandom)};
			2: return {1'($urandom), 8'd0, 23'($urandom)};
			3: return {1'($urandom), ($urandom_range(0, 1) ? 8'hff : 8'hfe), 23'($urandom)};
			default: return {1'($urandom), 8'($urandom_range(1, 254)), 23'($urandom)};
		endcase
	endfunction

	logic [31:0] corner[$] = '{
		32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00000,
		32'h7f800001, 32'hffffffff, 32'h7fbfffff, 32'h00000001, 32'h807fffff,
		32'h00400000, 32'h00800000, 32'h3f800000, 32'h40800000, 32'h3e800000,
		32'h41200000, 32'h7f7fffff, 32'hff7fffff, 32'hc0800000, 32'hbf800000,
		32'h5f3759df, 32'h3fffffff, 32'h7fffffff
	};

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		value_bits    = 32'd0;
		n_sub         = 0;
		n_special     = 0;
		send_idle_pct = 26;
		recv_idle_pct = 55;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner[i]) send(corner[i]);
		for (int i = 0; i < 160; i++) begin
			if (i == 80) drain();
			send(random_operand());
		end
		send_idle_pct = 55;
		recv_idle_pct = 26;
		for (int i = 0; i < 160; i++) send(random_operand());
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 160; i++) send(random_operand());
		drain();
		repeat (LATENCY + 10) @(posedge clk);

		$display("covered %0d operands (%0d zero/subnormal exponent, %0d inf/nan exponent),",
			sb.n_in, n_sub, n_special);
		$display("%0d results checked under three source/sink stall mixes", sb.n_out);
		if (sb.errors == 0 && sb.expected.size() == 0) begin
			$display("fast_inverse_sqrt_top_tb: PASS");
		end else begin
			$display("fast_inverse_sqrt_top_tb: FAIL");
		end
		$finish;
	end

endmodule
